### rtl/core/nec_pkg.sv
// Shared types and constants for the nearest-endpoint-to-corners block.
// Used by nec_lane and nearest_endpoint_to_corners; depends on nothing.
package nec_pkg;

    // Coordinate width and derived widths.
    localparam int COORD_BITS = 12;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int NUM_CORNERS = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Register reset values.
    localparam logic [COORD_BITS-1:0] IMAGE_WIDTH_RST  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] IMAGE_HEIGHT_RST = COORD_BITS'(480);

    // Corner numbering.
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BL = 2;
    localparam int CORNER_BR = 3;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Both endpoints of one segment.
    typedef struct packed {
        t_coord xa;
        t_coord ya;
        t_coord xb;
        t_coord yb;
    } t_pts;

    // Per-stage control that travels beside the segment.
    typedef struct packed {
        logic valid;
        logic ok;
        logic last;
    } t_ctl;

    // What one lane reports to the merging stage.
    typedef struct packed {
        logic   found_q;
        t_coord res_x;
        t_coord res_y;
    } t_lane_out;

endpackage

### rtl/core/nearest_endpoint_to_corners.sv
// The block accepts one segment per clock cycle while not stalled and reports the endpoint
// nearest to each image corner once the last segment has gone through: one input register,
// one stage of absolute differences, one stage of squaring multipliers, then the running
// minimums of the four corner lanes feed the output register. A corner that saw no segment
// with all coordinates nonzero reports (0,0). The only wait comes from the output side:
// while a result is held and stalled, the whole pipeline holds and the input stalls.
//
// Top level of nearest_endpoint_to_corners: input stage, four corner lanes, merge
// into the output register. Depends on nec_pkg and nec_lane.
module nearest_endpoint_to_corners (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Segment input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nec_pkg::t_coord                   i_x_a,
    input  nec_pkg::t_coord                   i_y_a,
    input  nec_pkg::t_coord                   i_x_b,
    input  nec_pkg::t_coord                   i_y_b,
    input  logic                              i_last,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nec_pkg::t_coord                   o_top_left_x,
    output nec_pkg::t_coord                   o_top_left_y,
    output nec_pkg::t_coord                   o_top_right_x,
    output nec_pkg::t_coord                   o_top_right_y,
    output nec_pkg::t_coord                   o_bottom_left_x,
    output nec_pkg::t_coord                   o_bottom_left_y,
    output nec_pkg::t_coord                   o_bottom_right_x,
    output nec_pkg::t_coord                   o_bottom_right_y,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nec_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  nec_pkg::t_coord                   i_cfg_data
);
    import nec_pkg::*;

    t_coord    r_image_width, r_image_height;
    t_coord    r_s1_w, r_s1_h;
    t_ctl      r_s1, r_s2, r_s3;
    t_ctl      n_s1;
    t_pts      r_s1_pts, r_s2_pts, r_s3_pts;
    logic      w_en;
    logic      r_out_valid;
    t_lane_out w_lane [NUM_CORNERS];
    t_coord    w_cx [NUM_CORNERS];
    t_coord    w_cy [NUM_CORNERS];
    t_coord    r_res_x [NUM_CORNERS];
    t_coord    r_res_y [NUM_CORNERS];

    // The pipeline moves unless a held result is stalled.
    assign w_en        = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: a segment with any zero coordinate is marked as skipped.
    always_comb begin
        n_s1.valid = i_in_valid;
        n_s1.ok    = (i_x_a != '0) && (i_y_a != '0) && (i_x_b != '0) && (i_y_b != '0);
        n_s1.last  = i_last;
    end

    // Control pipeline beside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Endpoint pipeline and the image size seen by each segment on arrival.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pts <= '{xa: i_x_a, ya: i_y_a, xb: i_x_b, yb: i_y_b};
            r_s1_w   <= r_image_width;
            r_s1_h   <= r_image_height;
            r_s2_pts <= r_s1_pts;
            r_s3_pts <= r_s2_pts;
        end
    end

    // Corner coordinates for each lane.
    always_comb begin
        w_cx[CORNER_TL] = '0;      w_cy[CORNER_TL] = '0;
        w_cx[CORNER_TR] = r_s1_w;  w_cy[CORNER_TR] = '0;
        w_cx[CORNER_BL] = '0;      w_cy[CORNER_BL] = r_s1_h;
        w_cx[CORNER_BR] = r_s1_w;  w_cy[CORNER_BR] = r_s1_h;
    end

    // One lane per corner.
    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
        nec_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_s1_pts (r_s1_pts),
            .i_cx     (w_cx[k]),
            .i_cy     (w_cy[k]),
            .i_s3_ctl (r_s3),
            .i_s3_pts (r_s3_pts),
            .o_res    (w_lane[k])
        );
    end

    // Merge: the output register collects all four lanes on the last segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s3.valid && r_s3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s3.valid && r_s3.last) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_res_x[k] <= w_lane[k].res_x;
                r_res_y[k] <= w_lane[k].res_y;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_top_left_x     = r_res_x[CORNER_TL];
    assign o_top_left_y     = r_res_y[CORNER_TL];
    assign o_top_right_x    = r_res_x[CORNER_TR];
    assign o_top_right_y    = r_res_y[CORNER_TR];
    assign o_bottom_left_x  = r_res_x[CORNER_BL];
    assign o_bottom_left_y  = r_res_y[CORNER_BL];
    assign o_bottom_right_x = r_res_x[CORNER_BR];
    assign o_bottom_right_y = r_res_y[CORNER_BR];

    // A new result appears only after a last segment left the final stage.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_s3.valid && r_s3.last))
        else $error("result appeared without a last segment");

    // After a last segment every lane starts the next frame empty.
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s3.valid && r_s3.last) |=>
        (!w_lane[CORNER_TL].found_q && !w_lane[CORNER_TR].found_q &&
         !w_lane[CORNER_BL].found_q && !w_lane[CORNER_BR].found_q))
        else $error("corner state not cleared after last segment");

    // A held, stalled result freezes the pipeline.
    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s3) && $stable(r_s2))
        else $error("pipeline moved while output stalled");

endmodule

### rtl/core/nec_lane.sv
// One corner lane: distance pipeline and running minimum for a single corner.
// Depends on nec_pkg.
module nec_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  nec_pkg::t_pts     i_s1_pts,
    input  nec_pkg::t_coord   i_cx,
    input  nec_pkg::t_coord   i_cy,
    input  nec_pkg::t_ctl     i_s3_ctl,
    input  nec_pkg::t_pts     i_s3_pts,
    output nec_pkg::t_lane_out o_res
);
    import nec_pkg::*;

    // Absolute differences to the corner.
    t_coord r_dxa, r_dya, r_dxb, r_dyb;
    t_coord n_dxa, n_dya, n_dxb, n_dyb;
    // Squared differences.
    logic [SQ_BITS-1:0] r_sxa, r_sya, r_sxb, r_syb;
    // Running minimum state.
    logic                 r_found;
    logic [DIST_BITS-1:0] r_best_d;
    t_coord               r_best_x, r_best_y;

    logic [DIST_BITS-1:0] w_da, w_db, w_mid_d, w_fin_d;
    logic                 w_take_a, w_take_b, w_fin_found;
    t_coord               w_mid_x, w_mid_y, w_fin_x, w_fin_y;

    // Stage two: absolute differences.
    always_comb begin
        n_dxa = (i_cx >= i_s1_pts.xa) ? i_cx - i_s1_pts.xa : i_s1_pts.xa - i_cx;
        n_dya = (i_cy >= i_s1_pts.ya) ? i_cy - i_s1_pts.ya : i_s1_pts.ya - i_cy;
        n_dxb = (i_cx >= i_s1_pts.xb) ? i_cx - i_s1_pts.xb : i_s1_pts.xb - i_cx;
        n_dyb = (i_cy >= i_s1_pts.yb) ? i_cy - i_s1_pts.yb : i_s1_pts.yb - i_cy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dxa <= n_dxa;
            r_dya <= n_dya;
            r_dxb <= n_dxb;
            r_dyb <= n_dyb;
        end
    end

    // Stage three: squares, one multiplier per difference.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sxa <= SQ_BITS'(r_dxa) * SQ_BITS'(r_dxa);
            r_sya <= SQ_BITS'(r_dya) * SQ_BITS'(r_dya);
            r_sxb <= SQ_BITS'(r_dxb) * SQ_BITS'(r_dxb);
            r_syb <= SQ_BITS'(r_dyb) * SQ_BITS'(r_dyb);
        end
    end

    // Offer the first endpoint, then the second; a tie keeps the earlier point.
    always_comb begin
        w_da     = DIST_BITS'(r_sxa) + DIST_BITS'(r_sya);
        w_db     = DIST_BITS'(r_sxb) + DIST_BITS'(r_syb);
        w_take_a = !r_found || (w_da < r_best_d);
        w_mid_d  = w_take_a ? w_da : r_best_d;
        w_mid_x  = w_take_a ? i_s3_pts.xa : r_best_x;
        w_mid_y  = w_take_a ? i_s3_pts.ya : r_best_y;
        w_take_b = w_db < w_mid_d;
        if (i_s3_ctl.ok) begin
            w_fin_found = 1'b1;
            w_fin_d     = w_take_b ? w_db : w_mid_d;
            w_fin_x     = w_take_b ? i_s3_pts.xb : w_mid_x;
            w_fin_y     = w_take_b ? i_s3_pts.yb : w_mid_y;
        end else begin
            w_fin_found = r_found;
            w_fin_d     = r_best_d;
            w_fin_x     = r_best_x;
            w_fin_y     = r_best_y;
        end
    end

    // Running minimum update; the last segment of a frame clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_en && i_s3_ctl.valid) begin
            r_found <= w_fin_found && !i_s3_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_s3_ctl.valid) begin
            r_best_d <= w_fin_d;
            r_best_x <= w_fin_x;
            r_best_y <= w_fin_y;
        end
    end

    // Frame result for this corner, zero when nothing was kept.
    assign o_res.found_q = r_found;
    assign o_res.res_x   = w_fin_found ? w_fin_x : '0;
    assign o_res.res_y   = w_fin_found ? w_fin_y : '0;

endmodule

### bench/nearest_endpoint_to_corners_test.sv
// Self-checking testbench for nearest_endpoint_to_corners: directed segments, then random
// frames under changing image sizes, checked against a corner tracker kept in the bench.
// Depends on nec_pkg and the nearest_endpoint_to_corners RTL.
`timescale 1ns / 100ps

module nearest_endpoint_to_corners_test;
    import nec_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 8;
    localparam int DIRECTED_ROWS = 20;

    // Register indexes that the block has no register for.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef t_point [NUM_CORNERS-1:0] t_corner_set;

    // One row of directed stimulus; typed rows carry the point all four corners report.
    typedef struct {
        t_coord xa;
        t_coord ya;
        t_coord xb;
        t_coord yb;
        logic   last;
        bit     typed;
        t_point typed_pt;
    } t_row;

    logic   i_clk    = 1'b0;
    logic   rst_n    = 1'b0;
    logic   seg_valid = 1'b0;
    t_coord seg_xa   = '0;
    t_coord seg_ya   = '0;
    t_coord seg_xb   = '0;
    t_coord seg_yb   = '0;
    logic   seg_last = 1'b0;
    bit     seg_typed = 1'b0;
    t_point seg_typed_pt = '0;
    logic   res_stall = 1'b0;
    logic   cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    t_coord cfg_data = '0;

    logic   o_in_stall;
    logic   o_out_valid;
    logic   o_cfg_ready;
    t_coord o_top_left_x, o_top_left_y, o_top_right_x, o_top_right_y;
    t_coord o_bottom_left_x, o_bottom_left_y, o_bottom_right_x, o_bottom_right_y;

    // Bench copy of the registers and of the per-corner running minimums.
    t_coord img_width  = IMAGE_WIDTH_RST;
    t_coord img_height = IMAGE_HEIGHT_RST;
    logic [DIST_BITS-1:0] near_dist [NUM_CORNERS] = '{default: '0};
    t_point near_pt [NUM_CORNERS] = '{default: '0};
    bit     near_seen [NUM_CORNERS] = '{default: 1'b0};

    t_corner_set pending_corners [$];
    string corner_label [NUM_CORNERS] = '{"top-left", "top-right", "bottom-left", "bottom-right"};
    t_row  directed_rows [DIRECTED_ROWS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int segs_accepted = 0;
    int segs_skipped  = 0;
    int frames_closed = 0;
    int cfg_writes    = 0;

    nearest_endpoint_to_corners i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (seg_valid),
        .o_in_stall       (o_in_stall),
        .i_x_a            (seg_xa),
        .i_y_a            (seg_ya),
        .i_x_b            (seg_xb),
        .i_y_b            (seg_yb),
        .i_last           (seg_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (res_stall),
        .o_top_left_x     (o_top_left_x),
        .o_top_left_y     (o_top_left_y),
        .o_top_right_x    (o_top_right_x),
        .o_top_right_y    (o_top_right_y),
        .o_bottom_left_x  (o_bottom_left_x),
        .o_bottom_left_y  (o_bottom_left_y),
        .o_bottom_right_x (o_bottom_right_x),
        .o_bottom_right_y (o_bottom_right_y),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Squared Euclidean distance from a corner to a point.
    function automatic logic [DIST_BITS-1:0] measure_distance(input t_coord cx, input t_coord cy,
                                                              input t_point p);
        logic [DIST_BITS-1:0] dx;
        logic [DIST_BITS-1:0] dy;
        dx = (cx >= p.x) ? DIST_BITS'(cx - p.x) : DIST_BITS'(p.x - cx);
        dy = (cy >= p.y) ? DIST_BITS'(cy - p.y) : DIST_BITS'(p.y - cy);
        return dx * dx + dy * dy;
    endfunction

    // Offer one endpoint to one corner; a tie keeps the point already held.
    function automatic void fold_endpoint(input int k, input t_point p);
        t_coord cx;
        t_coord cy;
        logic [DIST_BITS-1:0] d;
        cx = (k == CORNER_TR || k == CORNER_BR) ? img_width : t_coord'(0);
        cy = (k == CORNER_BL || k == CORNER_BR) ? img_height : t_coord'(0);
        d = measure_distance(cx, cy, p);
        if (!near_seen[k] || d < near_dist[k]) begin
            near_seen[k] = 1'b1;
            near_dist[k] = d;
            near_pt[k]   = p;
        end
    endfunction

    // Emit the kept points of the frame and start a fresh one.
    function automatic t_corner_set close_frame();
        t_corner_set kept;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            kept[k]      = near_seen[k] ? near_pt[k] : t_point'(0);
            near_seen[k] = 1'b0;
            near_dist[k] = '0;
            near_pt[k]   = '0;
        end
        return kept;
    endfunction

    // Every mismatch goes through here: one line, one count.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Compare an accepted result with the oldest pending frame.
    task automatic check_corners();
        t_corner_set got;
        t_corner_set want;
        got[CORNER_TL] = '{o_top_left_x, o_top_left_y};
        got[CORNER_TR] = '{o_top_right_x, o_top_right_y};
        got[CORNER_BL] = '{o_bottom_left_x, o_bottom_left_y};
        got[CORNER_BR] = '{o_bottom_right_x, o_bottom_right_y};
        if (pending_corners.size() == 0) begin
            report_mismatch("result item arrived with no frame pending");
            return;
        end
        want = pending_corners.pop_front();
        for (int k = 0; k < NUM_CORNERS; k++) begin
            if (got[k].x !== want[k].x)
                report_mismatch($sformatf("%s x: got %0d, expected %0d",
                                          corner_label[k], got[k].x, want[k].x));
            if (got[k].y !== want[k].y)
                report_mismatch($sformatf("%s y: got %0d, expected %0d",
                                          corner_label[k], got[k].y, want[k].y));
        end
    endtask

    // Track an accepted segment item.
    task automatic take_segment();
        t_corner_set kept;
        segs_accepted++;
        if (seg_xa != 0 && seg_ya != 0 && seg_xb != 0 && seg_yb != 0) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                fold_endpoint(k, '{seg_xa, seg_ya});
                fold_endpoint(k, '{seg_xb, seg_yb});
            end
        end else begin
            segs_skipped++;
        end
        if (seg_last) begin
            kept = close_frame();
            pending_corners.insert(pending_corners.size(),
                                   seg_typed ? t_corner_set'({NUM_CORNERS{seg_typed_pt}})
                                             : kept);
            frames_closed++;
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && !res_stall)
                check_corners();
            if (cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (cfg_index == CFG_IMAGE_WIDTH)
                    img_width = cfg_data;
                else if (cfg_index == CFG_IMAGE_HEIGHT)
                    img_height = cfg_data;
            end
            if (seg_valid && !o_in_stall)
                take_segment();
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one segment item, after a random gap, and hold it until accepted.
    task automatic send_segment(input t_coord xa, ya, xb, yb, input logic lst,
                                input bit typed, input t_point typed_pt);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_valid    <= 1'b1;
        seg_xa       <= xa;
        seg_ya       <= ya;
        seg_xb       <= xb;
        seg_yb       <= yb;
        seg_last     <= lst;
        seg_typed    <= typed;
        seg_typed_pt <= typed_pt;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Hold the sender off until every pending frame has been reported.
    task automatic wait_for_results();
        seg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_corners.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write, only once the pipeline has emptied.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_coord val);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random register write, leaning toward the extremes and the two real registers.
    task automatic update_config();
        logic [CFG_IDX_BITS-1:0] idx;
        t_coord val;
        case ($urandom_range(9))
            0:          idx = CFG_SPARE_2;
            1:          idx = CFG_SPARE_3;
            2, 3, 4, 5: idx = CFG_IMAGE_WIDTH;
            default:    idx = CFG_IMAGE_HEIGHT;
        endcase
        case ($urandom_range(7))
            0:       val = '0;
            1:       val = t_coord'(1);
            2:       val = '1;
            3:       val = IMAGE_WIDTH_RST;
            default: val = t_coord'($urandom_range(1, COORD_MAX));
        endcase
        write_reg(idx, val);
    endtask

    // Coordinate near an anchor, at an extreme, or anywhere; never zero.
    function automatic t_coord pick_coord(input t_coord anchor);
        int v;
        case ($urandom_range(9))
            0:       v = 1;
            1:       v = COORD_MAX;
            2, 3, 4: v = int'(anchor) + int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(1, COORD_MAX));
        endcase
        if (v < 1)
            v = 1;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return t_coord'(v);
    endfunction

    // Point drawn toward a random corner of the current image.
    function automatic t_point pick_point();
        t_point p;
        int k;
        k = $urandom_range(NUM_CORNERS - 1);
        p.x = pick_coord((k == CORNER_TR || k == CORNER_BR) ? img_width : t_coord'(1));
        p.y = pick_coord((k == CORNER_BL || k == CORNER_BR) ? img_height : t_coord'(1));
        return p;
    endfunction

    // Random frames: mostly short, well-formed ones, with ties and skipped segments mixed in.
    task automatic run_frames(input int seg_budget);
        int sent;
        int frame_len;
        t_point pa;
        t_point pb;
        t_point prev_pt;
        sent    = 0;
        prev_pt = pick_point();
        while (sent < seg_budget) begin
            if ($urandom_range(7) == 0)
                update_config();
            frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int j = 0; j < frame_len; j++) begin
                // Occasionally move the corners in the middle of a frame.
                if (j > 0 && $urandom_range(39) == 0)
                    update_config();
                pa = pick_point();
                case ($urandom_range(9))
                    0:       pb = pa;
                    1:       pb = '{pa.y, pa.x};
                    2:       pb = prev_pt;
                    default: pb = pick_point();
                endcase
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(4))
                        0:       pa.x = '0;
                        1:       pa.y = '0;
                        2:       pb.x = '0;
                        3:       pb.y = '0;
                        default: begin
                            pa = '0;
                            pb = '0;
                        end
                    endcase
                end
                prev_pt = pb;
                send_segment(pa.x, pa.y, pb.x, pb.y, (j == frame_len - 1), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed rows, then three random phases.
    initial begin
        directed_rows = '{
            '{12'd1,    12'd1,    12'd4095, 12'd4095, 1'b1, 1'b1, '{12'd1, 12'd1}},
            // A skipped last segment still closes the frame; no corner was found.
            '{12'd0,    12'd5,    12'd6,    12'd7,    1'b1, 1'b1, '{12'd0, 12'd0}},
            '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, '{12'd4095, 12'd4095}},
            // Equal distance to the top-left corner: the first endpoint stays.
            '{12'd3,    12'd4,    12'd4,    12'd3,    1'b1, 1'b0, '{12'd0, 12'd0}},
            '{12'd10,   12'd10,   12'd630,  12'd10,   1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd10,   12'd470,  12'd630,  12'd470,  1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd320,  12'd240,  12'd0,    12'd1,    1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd1,    12'd4095, 12'd4095, 12'd1,    1'b1, 1'b0, '{12'd0, 12'd0}},
            '{12'd4095, 12'd1,    12'd1,    12'd4095, 1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd2048, 12'd2048, 12'd2047, 12'd2047, 1'b1, 1'b0, '{12'd0, 12'd0}},
            // Each coordinate zero on its own skips the segment.
            '{12'd0,    12'd1,    12'd1,    12'd1,    1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd1,    12'd0,    12'd1,    12'd1,    1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd1,    12'd1,    12'd0,    12'd1,    1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd1,    12'd1,    12'd1,    12'd0,    1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd7,    12'd9,    12'd7,    12'd9,    1'b1, 1'b1, '{12'd7, 12'd9}},
            '{12'd100,  12'd200,  12'd100,  12'd200,  1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd100,  12'd200,  12'd50,   12'd60,   1'b1, 1'b0, '{12'd0, 12'd0}},
            // Point sitting exactly on the bottom-right corner.
            '{12'd640,  12'd480,  12'd640,  12'd480,  1'b0, 1'b0, '{12'd0, 12'd0}},
            '{12'd640,  12'd1,    12'd1,    12'd480,  1'b1, 1'b0, '{12'd0, 12'd0}},
            '{12'd2730, 12'd1365, 12'd1365, 12'd2730, 1'b1, 1'b0, '{12'd0, 12'd0}}
        };

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 29;
        recv_idle_pct <= 77;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_segment(directed_rows[i].xa, directed_rows[i].ya, directed_rows[i].xb,
                         directed_rows[i].yb, directed_rows[i].last, directed_rows[i].typed,
                         directed_rows[i].typed_pt);
        write_reg(CFG_IMAGE_WIDTH, t_coord'(COORD_MAX));
        write_reg(CFG_IMAGE_HEIGHT, t_coord'(COORD_MAX));
        run_frames(200);
        wait_for_results();

        // Sender idles heavily, receiver lightly, on the smallest image.
        send_idle_pct = 77;
        recv_idle_pct <= 29;
        write_reg(CFG_IMAGE_WIDTH, t_coord'(1));
        write_reg(CFG_IMAGE_HEIGHT, t_coord'(1));
        run_frames(215);
        wait_for_results();

        // No idling on either side; start from a zero-sized image.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        run_frames(215);

        // Drain, then watch a few more cycles for stray results.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d segments (%0d skipped) in %0d frames with %0d register writes.",
                 segs_accepted, segs_skipped, frames_closed, cfg_writes);
        $display("Idling ran sender-light, sender-heavy and gap-free; %0d mismatches seen.",
                 fail_count);
        if (fail_count == 0)
            $display("nearest_endpoint_to_corners_test passed");
        else
            $display("nearest_endpoint_to_corners_test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Timeout with %0d frames still pending.", pending_corners.size());
        $display("nearest_endpoint_to_corners_test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/nec_pkg.sv
rtl/core/nec_lane.sv
rtl/core/nearest_endpoint_to_corners.sv
bench/nearest_endpoint_to_corners_test.sv
